/* sv/sgr_pkg.sv */
// sgr_pkg: shared types and byte codes for the sgr attribute decoder
`default_nettype none

package sgr_pkg;

   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 3;
   localparam int CSR_IDX_W = 1;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_FG = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_BG = 1'b1;

   localparam logic [COLOR_W-1:0] RESET_DEFAULT_FG = 3'd7;
   localparam logic [COLOR_W-1:0] RESET_DEFAULT_BG = 3'd0;

   localparam logic [CHAR_W-1:0] BYTE_ESC   = 8'h1b;
   localparam logic [CHAR_W-1:0] BYTE_LF    = 8'h0a;
   localparam logic [CHAR_W-1:0] BYTE_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] BYTE_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] BYTE_ONE   = 8'h31;
   localparam logic [CHAR_W-1:0] BYTE_THREE = 8'h33;
   localparam logic [CHAR_W-1:0] BYTE_FOUR  = 8'h34;
   localparam logic [CHAR_W-1:0] BYTE_SEVEN = 8'h37;
   localparam logic [CHAR_W-1:0] BYTE_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] BYTE_M     = 8'h6d;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_SKIP  = 3'd1,
      MODE_PARAM = 3'd2,
      MODE_FG    = 3'd3,
      MODE_BG    = 3'd4
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  shown_char;
      logic [COLOR_W-1:0] foreground;
      logic [COLOR_W-1:0] background;
      logic               bold_on;
      logic               underline_on;
   } rsp_word_type;

endpackage

`default_nettype wire

/* sv/sgr_ctrl.sv */
// sgr_ctrl: escape sequence state machine, attribute and default colour registers
`default_nettype none

module sgr_ctrl
   import sgr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [CHAR_W-1:0]    text_byte,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]   csr_wdata,
   output rsp_word_type              word,
   output logic                      emit
);

   mode_type mode_ff, mode_in;
   logic [COLOR_W-1:0] def_fg_ff, def_bg_ff;
   logic [COLOR_W-1:0] fg_ff, fg_in, bg_ff, bg_in;
   logic bold_ff, bold_in, uline_ff, uline_in;

   logic is_digit, is_low_digit, seq_here;

   assign is_digit     = (text_byte >= BYTE_ZERO) && (text_byte <= BYTE_NINE);
   assign is_low_digit = (text_byte >= BYTE_ZERO) && (text_byte <= BYTE_SEVEN);
   // byte is treated as a sequence code: in param mode, or after '4' with no digit
   assign seq_here = (mode_ff == MODE_PARAM) || ((mode_ff == MODE_BG) && !is_digit);

   // next state
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (text_byte == BYTE_ESC) mode_in = MODE_SKIP;
         end
         MODE_SKIP: mode_in = MODE_PARAM;
         MODE_FG:   mode_in = MODE_PARAM;
         MODE_PARAM, MODE_BG: begin
            mode_in = MODE_PARAM;
            if (seq_here) begin
               case (text_byte)
                  BYTE_THREE: mode_in = MODE_FG;
                  BYTE_FOUR:  mode_in = MODE_BG;
                  BYTE_M:     mode_in = MODE_PLAIN;
                  default:    mode_in = MODE_PARAM;
               endcase
            end
         end
         default: mode_in = MODE_PLAIN;
      endcase
   end

   // attribute updates
   always_comb begin
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      bold_in  = bold_ff;
      uline_in = uline_ff;
      unique case (mode_ff)
         MODE_FG: begin
            if (is_low_digit) fg_in = text_byte[COLOR_W-1:0];
         end
         MODE_BG: begin
            if (is_low_digit) bg_in = text_byte[COLOR_W-1:0];
            else if (!is_digit) uline_in = 1'b1;
         end
         default: ;
      endcase
      if (seq_here) begin
         if (text_byte == BYTE_ZERO) begin
            fg_in    = def_fg_ff;
            bg_in    = def_bg_ff;
            bold_in  = 1'b0;
            uline_in = 1'b0;
         end else if (text_byte == BYTE_ONE) begin
            bold_in = 1'b1;
         end
      end
   end

   // outputs
   always_comb begin
      emit = (mode_ff == MODE_PLAIN) && (text_byte != BYTE_ESC) &&
             (text_byte != BYTE_LF) && (text_byte != BYTE_CR);
      word.shown_char   = text_byte;
      word.foreground   = fg_ff;
      word.background   = bg_ff;
      word.bold_on      = bold_ff;
      word.underline_on = uline_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_fg_ff <= RESET_DEFAULT_FG;
         def_bg_ff <= RESET_DEFAULT_BG;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEFAULT_FG: def_fg_ff <= csr_wdata;
            CSR_DEFAULT_BG: def_bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         fg_ff    <= RESET_DEFAULT_FG;
         bg_ff    <= RESET_DEFAULT_BG;
         bold_ff  <= 1'b0;
         uline_ff <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
         bold_ff  <= bold_in;
         uline_ff <= uline_in;
      end
   end

endmodule

`default_nettype wire

/* sv/sgr_out_reg.sv */
// sgr_out_reg: result register holding one word until the receiver takes it
`default_nettype none

module sgr_out_reg
   import sgr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   load,
   input  wire logic   load_valid,
   input  wire rsp_word_type load_word,
   output logic        out_valid,
   output rsp_word_type out_word
);

   logic         valid_ff;
   rsp_word_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= load_valid;
      end
   end

   // payload only moves when a new word is loaded
   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         word_ff <= load_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

/* sv/ansi_sgr_attribute_decoder.sv */
// ansi_sgr_attribute_decoder: top level, text byte in, attributed character out
//
// Bytes of a terminal text stream enter on the req_ channel (req_valid, req_stall,
// req_text_byte). Escape sequences are parsed to track foreground, background,
// bold and underline; every byte outside a sequence, other than CR and LF,
// leaves on the rsp_ channel as one word with the attributes in force.
// A byte is taken into an input register, decoded by one level of logic and
// the word lands in a result register, from which the receiver takes it.
// One byte per cycle is sustained while the receiver does not stall; escape
// bytes and CR/LF give no word.
// When the receiver stalls with a word waiting, the word holds and the input
// register keeps its byte; req_stall rises only while both are full, so a
// stall is passed back with one word of slack.
// Reset (synchronous) returns to plain text, restores the attributes to the
// reset defaults (foreground 7, background 0, bold and underline off) and
// empties both registers. csr_ writes set the colours that code '0' restores.
`default_nettype none

module ansi_sgr_attribute_decoder
   import sgr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [CHAR_W-1:0]    req_text_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CHAR_W-1:0]         rsp_shown_char,
   output logic [COLOR_W-1:0]        rsp_foreground,
   output logic [COLOR_W-1:0]        rsp_background,
   output logic                      rsp_bold_on,
   output logic                      rsp_underline_on,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]   csr_wdata
);

   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_byte_ff;
   logic              advance, fire, emit;
   rsp_word_type      word, out_word;

   assign advance   = !rsp_valid || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   sgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (in_byte_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .word      (word),
      .emit      (emit)
   );

   sgr_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (fire && emit),
      .load_word  (word),
      .out_valid  (rsp_valid),
      .out_word   (out_word)
   );

   assign rsp_shown_char   = out_word.shown_char;
   assign rsp_foreground   = out_word.foreground;
   assign rsp_background   = out_word.background;
   assign rsp_bold_on      = out_word.bold_on;
   assign rsp_underline_on = out_word.underline_on;

endmodule

`default_nettype wire

/* sv/sgr_checker.sv */
// sgr_assertions: port level checks for the sgr attribute decoder, with its bind
`default_nettype none

module sgr_assertions
   import sgr_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [CHAR_W-1:0]    rsp_shown_char
);

   // nothing is left over in the result register after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // control bytes never come out as words
   a_no_ctrl_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shown_char != BYTE_ESC) && (rsp_shown_char != BYTE_LF) &&
                    (rsp_shown_char != BYTE_CR))
      else $error("escape or line end byte emitted");

   // input side only backs up when a word is waiting and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with result side free");

   // a stalled word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shown_char))
      else $error("stalled result word changed");

endmodule

bind ansi_sgr_attribute_decoder sgr_assertions u_sgr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_shown_char (rsp_shown_char)
);

`default_nettype wire
